// ===== rtl/core/pcm_int_to_float_converter_unit_assert.svh =====
// assertion macros for the pcm integer to float converter
`ifndef PCM_INT_TO_FLOAT_CONVERTER_UNIT_ASSERT_SVH
`define PCM_INT_TO_FLOAT_CONVERTER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define PCMF_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcmf assertion failed");

// a stalled transfer keeps its valid and its data until taken
`define PCMF_ASSERT_HOLD(lbl, vld, rdy, dat) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (vld) && !(rdy) |=> (vld) && $stable(dat)) \
      else $error("pcmf stalled transfer changed");

`endif

// ===== rtl/core/pcmf_pkg.sv =====
// shared types and codes of the pcm integer to float converter
package pcmf_pkg;

   localparam logic [1:0] FMT_I16_LE = 2'd0;
   localparam logic [1:0] FMT_I16_BE = 2'd1;
   localparam logic [1:0] FMT_I32_LE = 2'd2;
   localparam logic [1:0] FMT_I32_BE = 2'd3;

   localparam logic [7:0] EXP_BASE_I16 = 8'd127;
   localparam logic [7:0] EXP_BASE_I32 = 8'd136;

   typedef struct packed {
      logic        sign;
      logic        zero;
      logic        is16;
      logic        sticky;
      logic [40:0] q;
   } frac_type;

   typedef struct packed {
      logic        sign;
      logic        zero;
      logic        sticky;
      logic [7:0]  exp;
      logic [40:0] n;
   } shift_type;

endpackage

// ===== rtl/core/pcmf_front.sv =====
// byte ordering, magnitude and scaled quotient stage
module pcmf_front import pcmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [1:0]  fmt,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] raw,
   output logic        out_valid,
   input  logic        out_ready,
   output frac_type    out_data
);

   logic        valid_ff, valid_in;
   frac_type    data_ff, data_in;
   logic [15:0] v16, mag16;
   logic [31:0] v32, mag32;

   always_comb begin
      v16 = raw[15:0];
      v32 = raw;
      unique case (fmt)
         FMT_I16_LE: v16 = raw[15:0];
         FMT_I16_BE: v16 = {raw[7:0], raw[15:8]};
         FMT_I32_LE: v32 = raw;
         FMT_I32_BE: v32 = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
         default:    v32 = raw;
      endcase
      mag16 = v16[15] ? 16'(16'd0 - v16) : v16;
      mag32 = v32[31] ? 32'(32'd0 - v32) : v32;
      data_in = '0;
      if (!fmt[1]) begin
         data_in.sign = v16[15];
         data_in.zero = (mag16 == 16'd0);
         data_in.is16 = 1'b1;
         // mag / (2^15 - 1) repeats the 15-bit pattern of mag
         if (mag16 == 16'h7fff) begin
            data_in.q      = 41'h1_0000_0000_00;
            data_in.sticky = 1'b0;
         end else if (mag16 == 16'h8000) begin
            data_in.q      = 41'h100_0200_0400;
            data_in.sticky = 1'b1;
         end else begin
            data_in.q      = {1'b0, mag16[14:0], mag16[14:0], mag16[14:5]};
            data_in.sticky = 1'b1;
         end
      end else begin
         data_in.sign   = v32[31];
         data_in.zero   = (mag32 == 32'd0);
         data_in.is16   = 1'b0;
         data_in.sticky = 1'b0;
         data_in.q      = {9'd0, mag32};
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`include "pcm_int_to_float_converter_unit_assert.svh"
   `PCMF_ASSERT_IMPL(a_q16_nonzero, valid_ff && data_ff.is16 && !data_ff.zero, data_ff.q[40:25] != 16'd0)
   `PCMF_ASSERT_IMPL(a_q32_narrow, valid_ff && !data_ff.is16, data_ff.q[40:32] == 9'd0 && !data_ff.sticky)

endmodule

// ===== rtl/core/pcmf_norm.sv =====
// leading zero count stage followed by normalizing shift stage
module pcmf_norm import pcmf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  frac_type  in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output shift_type out_data
);

   logic        lz_valid_ff, lz_valid_in, lz_ready;
   frac_type    lz_data_ff;
   logic [5:0]  lz_ff, lz_in;
   logic [7:0]  exp_ff, exp_in;
   logic        sh_valid_ff, sh_valid_in;
   shift_type   sh_data_ff, sh_data_in;

   always_comb begin
      lz_in = 6'd0;
      for (int i = 0; i <= 40; i++) begin
         if (in_data.q[i]) begin
            lz_in = 6'(40 - i);
         end
      end
      exp_in = (in_data.is16 ? EXP_BASE_I16 : EXP_BASE_I32) - {2'b00, lz_in};
   end

   assign lz_ready    = !sh_valid_ff || out_ready;
   assign in_ready    = !lz_valid_ff || lz_ready;
   assign lz_valid_in = in_ready ? in_valid : lz_valid_ff;
   assign sh_valid_in = lz_ready ? lz_valid_ff : sh_valid_ff;

   always_comb begin
      sh_data_in.sign   = lz_data_ff.sign;
      sh_data_in.zero   = lz_data_ff.zero;
      sh_data_in.sticky = lz_data_ff.sticky;
      sh_data_in.exp    = exp_ff;
      sh_data_in.n      = lz_data_ff.q << lz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lz_valid_ff <= 1'b0;
         sh_valid_ff <= 1'b0;
      end else begin
         lz_valid_ff <= lz_valid_in;
         sh_valid_ff <= sh_valid_in;
      end
      if (in_ready && in_valid) begin
         lz_data_ff <= in_data;
         lz_ff      <= lz_in;
         exp_ff     <= exp_in;
      end
      if (lz_ready && lz_valid_ff) begin
         sh_data_ff <= sh_data_in;
      end
   end

   assign out_valid = sh_valid_ff;
   assign out_data  = sh_data_ff;

`include "pcm_int_to_float_converter_unit_assert.svh"
   `PCMF_ASSERT_IMPL(a_normalized, sh_valid_ff && !sh_data_ff.zero, sh_data_ff.n[40])

endmodule

// ===== rtl/core/pcmf_round.sv =====
// round to nearest even and pack stage with output register
module pcmf_round import pcmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  shift_type   in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] out_data
);

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic [24:0] sum;
   logic [7:0]  exp;
   logic        guard, rest, inc;

   always_comb begin
      guard = in_data.n[16];
      rest  = (|in_data.n[15:0]) | in_data.sticky;
      inc   = guard & (rest | in_data.n[17]);
      sum   = {1'b0, in_data.n[40:17]} + {24'd0, inc};
      exp   = in_data.exp + {7'd0, sum[24]};
      data_in = in_data.zero ? 32'd0 : {in_data.sign, exp, sum[22:0]};
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`include "pcm_int_to_float_converter_unit_assert.svh"
   `PCMF_ASSERT_IMPL(a_no_denormal, valid_ff && data_ff[30:23] == 8'd0, data_ff == 32'd0)
   `PCMF_ASSERT_HOLD(a_out_hold, valid_ff, out_ready, data_ff)

endmodule

// ===== rtl/core/pcm_int_to_float_converter_unit.sv =====
// top level of the pcm integer to float converter
// Converts one raw PCM word per transfer into an IEEE single-precision
// pattern: 16-bit samples are scaled by 1/32767, 32-bit samples by 2^-31,
// both rounded to nearest even. The csr register picks the format
// (0 int16 le, 1 int16 be, 2 int32 le, 3 int32 be); write it only while
// idle. The pipeline has four register stages (byte order and quotient,
// leading zero count, normalizing shift, rounding); a sample passes them
// in that order before rsp_tvalid rises, and one sample per cycle is taken
// while the result side does not stall; a full stage holds only while the
// stage after it cannot take its item.
module pcm_int_to_float_converter_unit import pcmf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // raw_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // float_bits
);

   logic [1:0] fmt_ff;
   logic       f_valid, f_ready, n_valid, n_ready;
   frac_type   f_data;
   shift_type  n_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_I16_LE;
      end else if (csr_we) begin
         fmt_ff <= csr_wdata;
      end
   end

   pcmf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .fmt       (fmt_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .raw       (req_tdata),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   pcmf_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (n_valid),
      .out_ready (n_ready),
      .out_data  (n_data)
   );

   pcmf_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_valid),
      .in_ready  (n_ready),
      .in_data   (n_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
